// ----- hdl/osdc_pkg.sv -----
// Shared widths, register codes and beat types for the offset/deviation calibrator.
`default_nettype none
package osdc_pkg;

  // Default values for the top-level parameters.
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 8;

  // Fixed field and state widths.
  localparam int CNT_W     = 21;
  localparam int SUM_W     = 36;
  localparam int SQ_W      = 52;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 8;
  localparam int SMP_W     = 16;
  localparam int OFS_W     = 24;
  localparam int STD_W     = 23;
  localparam int DB_W      = 31;

  // The squared deviation is clamped to this many bits before the root.
  localparam int VAR_Q_W = 2 * STD_W;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd1;
  localparam logic [CNT_W-1:0]  WINDOW_RESET = 21'd1000;
  localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd256;

  // Largest sample count; further samples are dropped.
  localparam logic [CNT_W-1:0] MAX_COUNT = 21'd1048576;

  // Input commands.
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic                    command;
    logic signed [SMP_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [OFS_W-1:0] offset;
    logic [STD_W-1:0]        std_dev;
    logic [DB_W-1:0]         deadband;
    logic                    beyond_window;
    logic                    done_res;
    logic                    saturated;
  } out_item_t;

endpackage
`default_nettype wire

// ----- hdl/osdc_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
`default_nettype none
module osdc_mul #(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [AW-1:0]    a,
  input  wire logic [BW-1:0]    b,
  output logic                  busy,
  output logic [AW+BW-1:0]      prod
);

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0] a_r;
  logic [BW-1:0] b_r;
  logic [CW-1:0] cnt;

  assign busy = (cnt != '0);

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(BW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
    end
  end

  // Accumulate one partial product per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      prod <= '0;
    end else if (busy) begin
      b_r  <= b_r << 1;
      prod <= (prod << 1) + (b_r[BW-1] ? (AW+BW)'(a_r) : '0);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/osdc_div.sv -----
// Restoring bit-serial divider, one quotient bit per cycle.
`default_nettype none
module osdc_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DEN_W-1:0] rem_init,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic [NUM_W-1:0]      quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic [DEN_W:0]   sh;
  logic             ge;

  assign busy = (cnt != '0);

  // Trial subtraction of the shifted remainder.
  always_comb begin
    sh = {rem, quo[NUM_W-1]};
    ge = (sh >= {1'b0, den_r});
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
    end
  end

  // Numerator bits shift out the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem   <= rem_init;
      quo   <= num;
    end else if (busy) begin
      rem <= ge ? DEN_W'(sh - {1'b0, den_r}) : sh[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ----- hdl/osdc_sqrt.sv -----
// Digit-by-digit integer square root, one result bit per cycle.
`default_nettype none
module osdc_sqrt #(
  parameter int VW = 46
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [VW-1:0]   radicand,
  output logic                 busy,
  output logic [VW/2-1:0]      root
);

  localparam int RW = VW / 2;
  localparam int CW = $clog2(RW + 1);

  logic [VW-1:0] v_r;
  logic [VW-1:0] res;
  logic [VW-1:0] bit_r;
  logic [CW-1:0] cnt;
  logic [VW-1:0] trial;

  assign busy  = (cnt != '0);
  assign trial = res + bit_r;
  assign root  = res[RW-1:0];

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(RW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
    end
  end

  // One candidate bit of the root is tried each cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= radicand;
      res   <= '0;
      bit_r <= VW'(1) << (VW - 2);
    end else if (busy) begin
      if (v_r >= trial) begin
        v_r <= v_r - trial;
        res <= (res >> 1) + bit_r;
      end else begin
        res <= res >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/offset_stddev_deadband_calibrator_unit.sv -----
// Top level of the running offset, standard deviation and deadband calibrator.
//
//  Channel  | Direction | Handshake           | Beat
//  ---------+-----------+---------------------+-------------------------------
//  in       | input     | in_valid / in_stall | command, sample
//  out      | output    | out_valid/out_stall | offset, std_dev, deadband, flags
//  cfg      | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An add beat runs the serial square, the offset divide with the products, the variance
// divide, the root and the gain multiply in turn before its result is loaded; the next
// beat is taken only once the block is back in its idle state. A sample dropped at the
// count ceiling skips the square. A clear beat goes straight to the output state.
// Reset is synchronous; it restores the register defaults and empties the accumulators.
// A stalled result waits in the output register while the next input beat is already
// accepted.
`default_nettype none
module offset_stddev_deadband_calibrator_unit #(
  parameter int SAMPLE_BITS   = osdc_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = osdc_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire osdc_pkg::in_item_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output osdc_pkg::out_item_t                    out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [osdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [osdc_pkg::CNT_W-1:0]        cfg_data
);

  localparam int CNT_W  = osdc_pkg::CNT_W;
  localparam int SUM_W  = osdc_pkg::SUM_W;
  localparam int SQ_W   = osdc_pkg::SQ_W;
  localparam int M_W    = SAMPLE_BITS;
  localparam int NUM_W  = SUM_W + FRACTION_BITS + 1;
  localparam int PROD_W = CNT_W + SQ_W;
  localparam int D_W    = PROD_W + 2 * FRACTION_BITS;
  localparam int NN_W   = 2 * CNT_W;
  localparam int VQ_W   = osdc_pkg::VAR_Q_W;
  localparam int STD_W  = osdc_pkg::STD_W;
  localparam int GAIN_W = osdc_pkg::GAIN_W;
  localparam int OFS_W  = osdc_pkg::OFS_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SQ      = 4'd1;
  localparam logic [3:0] S_PREP    = 4'd2;
  localparam logic [3:0] S_LAUNCH  = 4'd3;
  localparam logic [3:0] S_MUL     = 4'd4;
  localparam logic [3:0] S_VLAUNCH = 4'd5;
  localparam logic [3:0] S_VDIV    = 4'd6;
  localparam logic [3:0] S_SQRT    = 4'd7;
  localparam logic [3:0] S_DB      = 4'd8;
  localparam logic [3:0] S_OUT     = 4'd9;

  logic [3:0] state;

  // Configuration and accumulators.
  logic [CNT_W-1:0]        window_size;
  logic [GAIN_W-1:0]       deadband_gain;
  logic [CNT_W-1:0]        sample_count;
  logic signed [SUM_W-1:0] sample_sum;
  logic [SQ_W-1:0]         square_sum;

  // Working registers.
  logic signed [M_W-1:0]   s_r;
  logic [CNT_W-1:0]        n_r;
  logic [SUM_W-1:0]        mag_r;
  logic                    neg_r;
  logic [D_W-1:0]          d_r;
  logic                    vsat_r;
  logic [OFS_W-1:0]        ofs_r;
  logic [STD_W-1:0]        sd_r;
  logic [osdc_pkg::DB_W-1:0] db_r;
  logic                    beyond_r;
  logic                    done_r;
  logic                    satf_r;

  // Unit handshakes and results.
  logic                    sq_start, par_start, var_start, rt_start, db_start;
  logic                    sq_busy, na_busy, mm_busy, nn_busy, od_busy, vd_busy;
  logic                    rt_busy, db_busy;
  logic [2*M_W-1:0]        sq_prod;
  logic [PROD_W-1:0]       ns_prod;
  logic [2*SUM_W-1:0]      mm_prod;
  logic [NN_W-1:0]         nn_prod;
  logic [NUM_W-1:0]        od_quo;
  logic [VQ_W-1:0]         vd_quo;
  logic [STD_W-1:0]        rt_root;
  logic [STD_W+GAIN_W-1:0] db_prod;

  // Combinational helpers.
  logic                    accept;
  logic signed [M_W-1:0]   s_in;
  logic [M_W-1:0]          m_in;
  logic [CNT_W-1:0]        n_max;
  logic [PROD_W-1:0]       dv;
  logic [D_W-1:0]          d_hi;
  logic [VQ_W-1:0]         rad;
  logic [OFS_W-1:0]        ofs_next;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  // Sample field, its magnitude and the larger of window size and sample count.
  always_comb begin
    s_in  = in_data.sample[M_W-1:0];
    m_in  = s_in[M_W-1] ? M_W'(-s_in) : M_W'(s_in);
    n_max = (window_size > sample_count) ? window_size : sample_count;
  end

  // Saturated rounded offset, variance numerator and its high part, clamped radicand.
  always_comb begin
    if (neg_r) begin
      ofs_next = (od_quo > NUM_W'(24'h800000)) ? 24'h800000 : (24'd0 - od_quo[OFS_W-1:0]);
    end else begin
      ofs_next = (od_quo > NUM_W'(24'h7FFFFF)) ? 24'h7FFFFF : od_quo[OFS_W-1:0];
    end
    dv   = ns_prod - PROD_W'(mm_prod);
    d_hi = d_r >> VQ_W;
    rad  = vsat_r ? '1 : vd_quo;
  end

  assign sq_start  = accept && (in_data.command == osdc_pkg::CMD_ADD) &&
                     (sample_count < osdc_pkg::MAX_COUNT);
  assign par_start = (state == S_LAUNCH);
  assign var_start = (state == S_VLAUNCH);
  assign rt_start  = (state == S_VDIV) && !vd_busy;
  assign db_start  = (state == S_SQRT) && !rt_busy;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= osdc_pkg::WINDOW_RESET;
      deadband_gain <= osdc_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        osdc_pkg::REG_WINDOW: window_size   <= cfg_data;
        osdc_pkg::REG_GAIN:   deadband_gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_count <= '0;
      sample_sum   <= '0;
      square_sum   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_data.command == osdc_pkg::CMD_CLEAR) begin
              sample_count <= '0;
              sample_sum   <= '0;
              square_sum   <= '0;
              state        <= S_OUT;
            end else if (sample_count < osdc_pkg::MAX_COUNT) begin
              state <= S_SQ;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_SQ: begin
          if (!sq_busy) begin
            sample_count <= sample_count + CNT_W'(1);
            sample_sum   <= sample_sum + SUM_W'(s_r);
            square_sum   <= square_sum + SQ_W'(sq_prod);
            state        <= S_PREP;
          end
        end
        S_PREP:    state <= S_LAUNCH;
        S_LAUNCH:  state <= S_MUL;
        S_MUL: begin
          if (!(na_busy || mm_busy || nn_busy || od_busy)) begin
            state <= S_VLAUNCH;
          end
        end
        S_VLAUNCH: state <= S_VDIV;
        S_VDIV: begin
          if (!vd_busy) begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (!rt_busy) begin
            state <= S_DB;
          end
        end
        S_DB: begin
          if (!db_busy) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers for the beat in progress.
  always_ff @(posedge clk) begin
    if (accept) begin
      s_r      <= s_in;
      beyond_r <= (in_data.command == osdc_pkg::CMD_ADD) &&
                  (sample_count >= window_size);
      satf_r   <= (in_data.command == osdc_pkg::CMD_ADD) &&
                  (sample_count >= osdc_pkg::MAX_COUNT);
      if (in_data.command == osdc_pkg::CMD_CLEAR) begin
        done_r   <= (window_size <= CNT_W'(1));
        ofs_r    <= '0;
        sd_r     <= '0;
        db_r     <= '0;
      end
    end
    if (state == S_PREP) begin
      n_r    <= (n_max == '0) ? CNT_W'(1) : n_max;
      neg_r  <= sample_sum[SUM_W-1];
      mag_r  <= sample_sum[SUM_W-1] ? SUM_W'(-sample_sum) : SUM_W'(sample_sum);
      done_r <= ((CNT_W+1)'(sample_count) + (CNT_W+1)'(1)) >= (CNT_W+1)'(n_max);
    end
    if (state == S_MUL) begin
      ofs_r  <= ofs_next;
      d_r    <= D_W'(dv) << (2 * FRACTION_BITS);
    end
    if (state == S_VLAUNCH) begin
      vsat_r <= (d_hi >= D_W'(nn_prod));
    end
    if (db_start) begin
      sd_r <= rt_root;
    end
    if ((state == S_DB) && !db_busy) begin
      db_r <= db_prod[osdc_pkg::GAIN_FRAC +: osdc_pkg::DB_W];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_OUT) && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!out_valid || !out_stall)) begin
      out_data.offset        <= ofs_r;
      out_data.std_dev       <= sd_r;
      out_data.deadband      <= db_r;
      out_data.beyond_window <= beyond_r;
      out_data.done_res      <= done_r;
      out_data.saturated     <= satf_r;
    end
  end

  // Square of the new sample.
  osdc_mul #(.AW(M_W), .BW(M_W)) u_sq (
    .clk(clk), .rst(rst), .start(sq_start), .a(m_in), .b(m_in),
    .busy(sq_busy), .prod(sq_prod)
  );

  // N times the sum of squares.
  osdc_mul #(.AW(SQ_W), .BW(CNT_W)) u_ns (
    .clk(clk), .rst(rst), .start(par_start), .a(square_sum), .b(n_r),
    .busy(na_busy), .prod(ns_prod)
  );

  // Square of the sum magnitude.
  osdc_mul #(.AW(SUM_W), .BW(SUM_W)) u_mm (
    .clk(clk), .rst(rst), .start(par_start), .a(mag_r), .b(mag_r),
    .busy(mm_busy), .prod(mm_prod)
  );

  // N squared, the variance divisor.
  osdc_mul #(.AW(CNT_W), .BW(CNT_W)) u_nn (
    .clk(clk), .rst(rst), .start(par_start), .a(n_r), .b(n_r),
    .busy(nn_busy), .prod(nn_prod)
  );

  // Rounded mean divide.
  osdc_div #(.NUM_W(NUM_W), .DEN_W(CNT_W)) u_odiv (
    .clk(clk), .rst(rst), .start(par_start), .rem_init('0),
    .num((NUM_W'(mag_r) << FRACTION_BITS) + NUM_W'(n_r >> 1)),
    .den(n_r), .busy(od_busy), .quo(od_quo)
  );

  // Variance divide; the high part of the numerator seeds the remainder.
  osdc_div #(.NUM_W(VQ_W), .DEN_W(NN_W)) u_vdiv (
    .clk(clk), .rst(rst), .start(var_start), .rem_init(d_hi[NN_W-1:0]),
    .num(d_r[VQ_W-1:0]), .den(nn_prod), .busy(vd_busy), .quo(vd_quo)
  );

  osdc_sqrt #(.VW(VQ_W)) u_sqrt (
    .clk(clk), .rst(rst), .start(rt_start), .radicand(rad),
    .busy(rt_busy), .root(rt_root)
  );

  // Deviation times gain.
  osdc_mul #(.AW(STD_W), .BW(GAIN_W)) u_db (
    .clk(clk), .rst(rst), .start(db_start), .a(rt_root), .b(deadband_gain),
    .busy(db_busy), .prod(db_prod)
  );

  // The count never passes its ceiling.
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    sample_count <= osdc_pkg::MAX_COUNT)
    else $error("sample count above its maximum");

  // A result beat appears only from the output state.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result loaded outside the output state");

  // No arithmetic unit runs while the block waits for input.
  a_idle_units: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !(sq_busy || na_busy || mm_busy || nn_busy ||
                            od_busy || vd_busy || rt_busy || db_busy))
    else $error("unit busy while idle");

  // The scaled variance is never negative.
  a_var_sign: assert property (@(posedge clk) disable iff (rst)
    ((state == S_MUL) && !(na_busy || mm_busy || nn_busy || od_busy))
      |-> (ns_prod >= PROD_W'(mm_prod)))
    else $error("negative variance numerator");

endmodule
`default_nettype wire

// ----- dv/offset_stddev_deadband_calibrator_unit_test.sv -----
// Self-checking testbench for the offset, standard deviation and deadband calibrator.
`timescale 1ns / 1ps
module offset_stddev_deadband_calibrator_unit_test;

  localparam int FRAC        = osdc_pkg::FRACTION_BITS_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_WAIT  = 250;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  osdc_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  osdc_pkg::out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [osdc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [osdc_pkg::CNT_W-1:0] cfg_data;

  offset_stddev_deadband_calibrator_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the calibrator registers and accumulators.
  logic [osdc_pkg::CNT_W-1:0]         win_size;
  logic [osdc_pkg::GAIN_W-1:0]        db_gain;
  logic [osdc_pkg::CNT_W-1:0]         acc_count = '0;
  logic signed [osdc_pkg::SUM_W-1:0]  acc_sum = '0;
  logic [osdc_pkg::SQ_W-1:0]          acc_sqsum = '0;

  osdc_pkg::in_item_t  pending_beats[$];
  osdc_pkg::out_item_t expected_stats[$];
  int   error_count = 0;
  int   checked_count = 0;
  int   clear_count = 0;
  int   cycle_count = 0;
  bit   idle_enable;
  int   send_gap = 0;
  int   recv_gap = 0;

  // Integer square root, bit by bit, floor.
  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Mean, deviation and deadband of the current accumulators.
  function automatic osdc_pkg::out_item_t stats_from_accum();
    osdc_pkg::out_item_t r;
    logic [63:0]  n;
    logic [63:0]  mag;
    logic [63:0]  q;
    logic [63:0]  sd;
    logic [63:0]  db;
    logic [127:0] dv;
    logic [127:0] quo;
    bit neg;
    n = (win_size > acc_count) ? 64'(win_size) : 64'(acc_count);
    if (n == 0) n = 1;
    neg = acc_sum < 0;
    mag = neg ? (64'd0 - 64'(acc_sum)) : 64'(acc_sum);
    r = '0;
    q = ((mag << FRAC) + n / 2) / n;
    if (neg) r.offset = (q > 64'd8388608) ? 24'h800000 : 24'(-q);
    else r.offset = (q > 64'd8388607) ? 24'h7FFFFF : 24'(q);
    dv = 128'(n) * 128'(acc_sqsum) - 128'(mag) * 128'(mag);
    dv = dv << (2 * FRAC);
    quo = dv / (128'(n) * 128'(n));
    sd = int_sqrt((quo[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : quo[63:0]);
    if (sd > 64'd8388607) sd = 64'd8388607;
    r.std_dev = sd[osdc_pkg::STD_W-1:0];
    db = (sd * 64'(db_gain)) >> osdc_pkg::GAIN_FRAC;
    if (db > 64'd2147483647) db = 64'd2147483647;
    r.deadband = db[osdc_pkg::DB_W-1:0];
    return r;
  endfunction

  // Advance the shadow state by one input beat and return the expected result.
  function automatic osdc_pkg::out_item_t apply_beat(osdc_pkg::in_item_t it);
    osdc_pkg::out_item_t r;
    logic [63:0] n;
    logic [63:0] m;
    if (it.command == osdc_pkg::CMD_CLEAR) begin
      acc_count = 0;
      acc_sum = 0;
      acc_sqsum = 0;
      r = '0;
      r.done_res = (win_size <= 1);
      return r;
    end
    if (acc_count >= osdc_pkg::MAX_COUNT) begin
      r = stats_from_accum();
      r.saturated = 1'b1;
      r.beyond_window = (acc_count >= win_size);
    end else begin
      r.beyond_window = (acc_count >= win_size);
      m = (it.sample < 0) ? 64'(-64'(it.sample)) : 64'(it.sample);
      acc_count = acc_count + 1;
      acc_sum = acc_sum + osdc_pkg::SUM_W'(it.sample);
      acc_sqsum = acc_sqsum + osdc_pkg::SQ_W'(m * m);
      r = stats_from_accum();
      r.beyond_window = (acc_count - 1 >= win_size);
      r.saturated = 1'b0;
    end
    n = (win_size > acc_count) ? 64'(win_size) : 64'(acc_count);
    r.done_res = (64'(acc_count) + 1 >= n);
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("MISMATCH result %0d field %s: got %0d, expected %0d",
             checked_count, field, got, want);
    error_count++;
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("offset_stddev_deadband_calibrator_unit verification failed");
      $finish;
    end
  end

  // Input driver: predicts each accepted beat, then presents the next one.
  always @(posedge clk) begin
    osdc_pkg::in_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        expected_stats.insert(expected_stats.size(), apply_beat(in_data));
        if (in_data.command == osdc_pkg::CMD_CLEAR) clear_count++;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        nxt = pending_beats.pop_front();
        in_data <= nxt;
        in_valid <= 1'b1;
        if (idle_enable && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 17);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor: checks each result beat and stalls in random bursts.
  always @(posedge clk) begin
    osdc_pkg::out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_stats.size() == 0) begin
          $display("Unexpected result beat at cycle %0d", cycle_count);
          error_count++;
        end else begin
          want = expected_stats.pop_front();
          if (out_data.offset !== want.offset)
            report_mismatch("offset", out_data.offset, want.offset);
          if (out_data.std_dev !== want.std_dev)
            report_mismatch("std_dev", out_data.std_dev, want.std_dev);
          if (out_data.deadband !== want.deadband)
            report_mismatch("deadband", out_data.deadband, want.deadband);
          if (out_data.beyond_window !== want.beyond_window)
            report_mismatch("beyond_window", out_data.beyond_window, want.beyond_window);
          if (out_data.done_res !== want.done_res)
            report_mismatch("done_res", out_data.done_res, want.done_res);
          if (out_data.saturated !== want.saturated)
            report_mismatch("saturated", out_data.saturated, want.saturated);
          checked_count++;
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Register write through the configuration channel, mirrored in the shadow copy.
  task automatic write_reg(logic [osdc_pkg::CFG_IDX_W-1:0] idx,
                           logic [osdc_pkg::CNT_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == osdc_pkg::REG_WINDOW) win_size = val;
    else if (idx == osdc_pkg::REG_GAIN) db_gain = val[osdc_pkg::GAIN_W-1:0];
  endtask

  // Hold off until every expected result is back and the block has settled.
  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid || expected_stats.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic queue_beat(logic cmd, logic signed [osdc_pkg::SMP_W-1:0] smp);
    osdc_pkg::in_item_t it;
    it.command = cmd;
    it.sample = smp;
    pending_beats.insert(pending_beats.size(), it);
  endtask

  // Random beats: mostly samples, some extremes, an occasional clear.
  task automatic queue_random(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 4) begin
        queue_beat(osdc_pkg::CMD_CLEAR, osdc_pkg::SMP_W'($urandom));
      end else if (k < 12) begin
        queue_beat(osdc_pkg::CMD_ADD, $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000);
      end else if (k < 30) begin
        queue_beat(osdc_pkg::CMD_ADD, osdc_pkg::SMP_W'($urandom_range(0, 64) - 32));
      end else begin
        queue_beat(osdc_pkg::CMD_ADD, osdc_pkg::SMP_W'($urandom));
      end
    end
  endtask

  // Stimulus sequence.
  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = osdc_pkg::REG_WINDOW;
    cfg_data = '0;
    idle_enable = 1'b1;
    win_size = osdc_pkg::WINDOW_RESET;
    db_gain = osdc_pkg::GAIN_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset registers, field extremes and a clear.
    queue_beat(osdc_pkg::CMD_ADD, 16'sh7FFF);
    queue_beat(osdc_pkg::CMD_ADD, 16'sh8000);
    queue_beat(osdc_pkg::CMD_ADD, 16'sh0000);
    queue_beat(osdc_pkg::CMD_ADD, -16'sd1);
    queue_beat(osdc_pkg::CMD_ADD, 16'sd1);
    queue_beat(osdc_pkg::CMD_ADD, 16'sh5555);
    queue_beat(osdc_pkg::CMD_ADD, 16'shAAAA);
    queue_beat(osdc_pkg::CMD_CLEAR, 16'shFFFF);
    queue_beat(osdc_pkg::CMD_ADD, 16'sh8000);
    queue_beat(osdc_pkg::CMD_ADD, 16'sh8000);
    wait_drained();

    // Tiny windows: one-sample window, zero window, beyond-window flags.
    write_reg(osdc_pkg::REG_WINDOW, 21'd1);
    write_reg(osdc_pkg::REG_GAIN, 21'd0);
    queue_beat(osdc_pkg::CMD_CLEAR, 16'sd0);
    queue_beat(osdc_pkg::CMD_ADD, 16'sd100);
    queue_beat(osdc_pkg::CMD_ADD, -16'sd100);
    queue_beat(osdc_pkg::CMD_ADD, 16'sh7FFF);
    wait_drained();
    write_reg(osdc_pkg::REG_WINDOW, 21'd0);
    write_reg(osdc_pkg::REG_GAIN, 21'd65535);
    queue_beat(osdc_pkg::CMD_CLEAR, 16'sd0);
    queue_beat(osdc_pkg::CMD_ADD, 16'sh8000);
    queue_beat(osdc_pkg::CMD_ADD, 16'sh7FFF);
    queue_beat(osdc_pkg::CMD_ADD, 16'sh8000);
    queue_random(200);
    wait_drained();

    // Window at the count ceiling, gain kept at its largest.
    write_reg(osdc_pkg::REG_WINDOW, 21'd1048576);
    queue_random(200);
    wait_drained();

    // Small window so done and beyond-window flags toggle often.
    write_reg(osdc_pkg::REG_WINDOW, 21'd5);
    write_reg(osdc_pkg::REG_GAIN, 21'd300);
    queue_random(200);
    wait_drained();

    // Random register settings.
    write_reg(osdc_pkg::REG_WINDOW, osdc_pkg::CNT_W'($urandom_range(1, 300)));
    write_reg(osdc_pkg::REG_GAIN, osdc_pkg::CNT_W'($urandom_range(0, 65535)));
    queue_random(200);
    wait_drained();

    // Last stretch at full rate with no idling.
    write_reg(osdc_pkg::REG_WINDOW, 21'd64);
    write_reg(osdc_pkg::REG_GAIN, 21'd256);
    idle_enable = 1'b0;
    queue_random(200);
    wait_drained();

    $display("Checked %0d results (%0d clears) with random stalls on both sides,",
             checked_count, clear_count);
    $display("over window sizes 0 to 1048576 and gains 0 to 65535.");
    if (error_count == 0 && expected_stats.size() == 0) begin
      $display("offset_stddev_deadband_calibrator_unit verification clean");
    end else begin
      $display("offset_stddev_deadband_calibrator_unit verification failed");
    end
    $finish;
  end

endmodule
